// ===== src/cptp_pkg.sv =====
// Shared widths, the slot entry type and the command codes of the task picker.
`default_nettype none

package cptp_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned PRI_W     = 7;
  localparam int unsigned IN_W      = 24;
  localparam int unsigned OUT_W     = 8;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SCHED = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [PRI_W-1:0] prio;
    logic [CNT_W-1:0] cnt;
    logic             runnable;
    logic             present;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/counter_priority_task_picker.sv =====
// Top level of the counter/priority task picker with its scan and refresh sequencer.
//
// A write beat (tuser 0) loads one slot; writes to a slot at or above SLOTS are
// dropped. A schedule beat (tuser 1) gives one result beat. The sequencer walks
// the slot table through its single read port, one slot per cycle from SLOTS-1
// down to 1; when the best counter is zero a refresh pass (reading and writing
// back one slot a cycle) and a second scan follow. The input side is not ready
// while a decision is in progress. Slot zero is never chosen; next_slot is zero
// when nothing is runnable, and the stalled flag is set when runnable slots stay
// at a zero counter after refresh.
`default_nettype none

module counter_priority_task_picker #(
  parameter int unsigned SLOTS = cptp_pkg::SLOTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // slot[5:0], present[6], runnable[7], counter_value[15:8], priority_value[22:16]
  input  wire logic [cptp_pkg::IN_W-1:0]  s_axis_tdata_i,
  // command[0]
  input  wire logic                       s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  // next_slot[5:0], refreshed[6], stalled[7]
  output logic [cptp_pkg::OUT_W-1:0]      m_axis_tdata_o
);
  import cptp_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REFRESH,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   addr_q;
  logic               issue_q;
  logic               rv_q;
  logic               rlast_q;
  logic [IDX_W-1:0]   ridx_q;
  logic               found_q;
  logic [CNT_W-1:0]   best_cnt_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic               refr_q;
  logic [SLOT_W-1:0]  res_slot_q;
  logic               res_stall_q;
  logic               m_valid_q;
  logic [OUT_W-1:0]   m_data_q;

  entry_t             rd_entry;
  entry_t             in_entry;
  entry_t             refr_entry;
  logic               in_acc;
  logic               in_ok;
  logic               take;
  logic               nf;
  logic [CNT_W-1:0]   nc;
  logic [IDX_W-1:0]   ni;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_entry;
  logic [CNT_W:0]     refr_sum;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_ok           = ({3'b000, s_axis_tdata_i[5:0]} < 9'(SLOTS));

  always_comb begin
    in_entry.present  = s_axis_tdata_i[6];
    in_entry.runnable = s_axis_tdata_i[7];
    in_entry.cnt      = s_axis_tdata_i[15:8];
    in_entry.prio     = s_axis_tdata_i[22:16];
  end

  // Running maximum; a lower slot must be strictly larger to replace the holder.
  always_comb begin
    take = rd_entry.present && rd_entry.runnable &&
           (!found_q || (rd_entry.cnt > best_cnt_q));
    nf   = found_q || take;
    nc   = take ? rd_entry.cnt : best_cnt_q;
    ni   = take ? ridx_q : best_idx_q;
  end

  always_comb begin
    refr_sum       = {2'b00, rd_entry.cnt[CNT_W-1:1]} + {2'b00, rd_entry.prio};
    refr_entry     = rd_entry;
    refr_entry.cnt = refr_sum[CNT_W-1:0];
  end

  always_comb begin
    if (state_q == ST_REFRESH) begin
      wr_en    = rv_q && rd_entry.present;
      wr_idx   = ridx_q;
      wr_entry = refr_entry;
    end else begin
      wr_en    = in_acc && (cmd_e'(s_axis_tuser_i) == CMD_WRITE) && in_ok;
      wr_idx   = IDX_W'(s_axis_tdata_i[5:0]);
      wr_entry = in_entry;
    end
  end

  cptp_table #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_entry_i (wr_entry),
    .rd_idx_i   (addr_q),
    .rd_entry_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      addr_q      <= '0;
      issue_q     <= 1'b0;
      rv_q        <= 1'b0;
      rlast_q     <= 1'b0;
      ridx_q      <= '0;
      found_q     <= 1'b0;
      best_cnt_q  <= '0;
      best_idx_q  <= '0;
      refr_q      <= 1'b0;
      res_slot_q  <= '0;
      res_stall_q <= 1'b0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      // In the done state the result register is handled by the state machine below.
      if (m_valid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end

      // Read issue: the table answers in the cycle after the address is presented.
      if ((state_q == ST_SCAN || state_q == ST_REFRESH) && issue_q) begin
        rv_q    <= 1'b1;
        ridx_q  <= addr_q;
        rlast_q <= (addr_q == ONE_IDX);
        if (addr_q == ONE_IDX) begin
          issue_q <= 1'b0;
        end else begin
          addr_q <= addr_q - ONE_IDX;
        end
      end else begin
        rv_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (cmd_e'(s_axis_tuser_i) == CMD_SCHED)) begin
            state_q <= ST_SCAN;
            found_q <= 1'b0;
            refr_q  <= 1'b0;
            addr_q  <= TOP_IDX;
            issue_q <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (rv_q) begin
            found_q    <= nf;
            best_cnt_q <= nc;
            best_idx_q <= ni;
            if (rlast_q) begin
              if (!nf) begin
                res_slot_q  <= '0;
                res_stall_q <= 1'b0;
                state_q     <= ST_DONE;
              end else if (nc != '0) begin
                res_slot_q  <= SLOT_W'(ni);
                res_stall_q <= 1'b0;
                state_q     <= ST_DONE;
              end else if (refr_q) begin
                res_slot_q  <= '0;
                res_stall_q <= 1'b1;
                state_q     <= ST_DONE;
              end else begin
                state_q <= ST_REFRESH;
                addr_q  <= TOP_IDX;
                issue_q <= 1'b1;
              end
            end
          end
        end
        ST_REFRESH: begin
          if (rv_q && rlast_q) begin
            state_q <= ST_SCAN;
            refr_q  <= 1'b1;
            found_q <= 1'b0;
            addr_q  <= TOP_IDX;
            issue_q <= 1'b1;
          end
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {res_stall_q, refr_q, res_slot_q};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // A stalled decision has always refreshed and never names a slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q[7] |-> m_data_q[6] && (m_data_q[5:0] == '0))
    else $error("stalled result without refresh or with a slot");

  // Slot zero is never read for a decision or a refresh.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> ridx_q != '0)
    else $error("slot zero reached by the sequencer");

  // A refresh pass runs at most once per decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && (state_q != $past(state_q)) && ($past(state_q) == ST_REFRESH)
    |-> !$past(refr_q))
    else $error("second refresh pass in one decision");

  // The result register is only loaded when it is free or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_axis_tready_i |=> $stable(m_data_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== src/cptp_table.sv =====
// Slot table: one-write, one-read memory with per-entry valid bits for reset.
`default_nettype none

module cptp_table #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned IDX_W = $clog2(SLOTS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire cptp_pkg::entry_t wr_entry_i,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  output cptp_pkg::entry_t      rd_entry_o
);
  import cptp_pkg::*;

  entry_t           mem_q [SLOTS];
  entry_t           rd_q;
  logic             rd_vld_q;
  logic [SLOTS-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_entry_i;
    end
    rd_q <= mem_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      rd_vld_q <= valid_q[rd_idx_i];
    end
  end

  // An entry never written since reset reads as all zero.
  assign rd_entry_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire
